// File: src/tsp_pkg.sv
package tsp_pkg;

    localparam int MAX_SEGMENTS_DEFAULT = 64;
    localparam int QUEUE_DEPTH          = 2;

    localparam logic [7:0] LINK_HEADER_MAX = 8'd32;

    localparam logic [1:0] CFG_HW_CHECKSUM     = 2'd0;
    localparam logic [1:0] CFG_LINK_HEADER_LEN = 2'd1;
    localparam logic [1:0] CFG_MAX_L3_LEN      = 2'd2;

    localparam logic [1:0] STATUS_SEGMENT     = 2'd0;
    localparam logic [1:0] STATUS_UNSUPPORTED = 2'd1;
    localparam logic [1:0] STATUS_TOO_MANY    = 2'd2;

    localparam logic [1:0] OFFLOAD_SOFTWARE = 2'd0;
    localparam logic [1:0] OFFLOAD_TCP_IPV4 = 2'd1;
    localparam logic [1:0] OFFLOAD_TCP_IPV6 = 2'd2;

    localparam logic [3:0] IP_VERSION_6      = 4'd6;
    localparam logic [7:0] PROTO_TCP         = 8'd6;
    localparam logic [6:0] IPV6_HEADER_BYTES = 7'd40;
    localparam logic [6:0] MIN_HEADER_BYTES  = 7'd20;

    localparam logic [11:0] FLAGS_LAST_ONLY  = 12'h009;
    localparam logic [11:0] FLAGS_FIRST_ONLY = 12'h080;

    typedef struct packed {
        logic        hw_checksum;
        logic [7:0]  link_header_len;
        logic [15:0] max_l3_len;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  ip_version;
        logic [7:0]  next_protocol;
        logic [3:0]  ipv4_header_words;
        logic        fragment_marked;
        logic [3:0]  tcp_header_words;
        logic [16:0] frame_len;
        logic [15:0] segment_size;
        logic [31:0] start_seq;
        logic [15:0] start_ip_id;
        logic [11:0] tcp_flags;
        logic        unmapped_payload;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] seg_seq;
        logic [16:0] payload_offset;
        logic [15:0] payload_len;
        logic [15:0] l3_length_field;
        logic [15:0] seg_ip_id;
        logic [11:0] seg_tcp_flags;
        logic [1:0]  offload_kind;
        logic        is_ipv6;
        logic [7:0]  header_len;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_ipv6;
        logic [1:0]  offload_kind;
        logic [7:0]  header_len;
        logic [5:0]  tcp_len;
        logic [6:0]  l34_len;
        logic [15:0] seg_size;
        logic [16:0] pay_len;
        logic [31:0] start_seq;
        logic [15:0] start_ip_id;
        logic [11:0] tcp_flags;
    } plan_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CLASSIFY,
        F_LIMIT
    } front_state_t;

endpackage

// File: src/tsp_if.sv
interface tsp_item_if import tsp_pkg::*; ();
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface tsp_result_if import tsp_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: src/tsp_front.sv
module tsp_front import tsp_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    tsp_item_if.sink        in_ch,
    input  logic            q_full,
    output logic            q_push,
    output plan_t           q_data
);

    localparam int CntW  = $clog2(MAX_SEGMENTS + 1);
    localparam int ProdW = 16 + CntW;

    front_state_t state_reg, state_next;
    item_t        item_reg;
    plan_t        plan_reg, plan_next;

    logic              v6;
    logic [6:0]        ip_len;
    logic [5:0]        tcp_len;
    logic [6:0]        l34_len;
    logic [8:0]        hdr_len;
    logic [15:0]       room;
    logic              reject;
    logic [ProdW-1:0]  limit;
    logic              too_many;

    // classification of the captured item
    always_comb
    begin
        v6      = (item_reg.ip_version == IP_VERSION_6);
        ip_len  = v6 ? IPV6_HEADER_BYTES : {1'b0, item_reg.ipv4_header_words, 2'b00};
        tcp_len = {item_reg.tcp_header_words, 2'b00};
        l34_len = ip_len + {1'b0, tcp_len};
        hdr_len = {1'b0, cfg.link_header_len} + {2'b00, l34_len};
        room    = cfg.max_l3_len - {9'd0, l34_len};
        reject  = (cfg.link_header_len > LINK_HEADER_MAX)
               || (item_reg.segment_size == 16'd0)
               || (!cfg.hw_checksum && item_reg.unmapped_payload)
               || (item_reg.next_protocol != PROTO_TCP)
               || (!v6 && ((ip_len < MIN_HEADER_BYTES) || item_reg.fragment_marked))
               || ({1'b0, tcp_len} < MIN_HEADER_BYTES)
               || (item_reg.frame_len <= {8'd0, hdr_len})
               || ((cfg.max_l3_len != 16'd0) && (cfg.max_l3_len <= {9'd0, l34_len}));

        plan_next              = '0;
        plan_next.status       = reject ? STATUS_UNSUPPORTED : STATUS_SEGMENT;
        plan_next.is_ipv6      = v6;
        plan_next.offload_kind = !cfg.hw_checksum ? OFFLOAD_SOFTWARE
                               : (v6 ? OFFLOAD_TCP_IPV6 : OFFLOAD_TCP_IPV4);
        plan_next.header_len   = hdr_len[7:0];
        plan_next.tcp_len      = tcp_len;
        plan_next.l34_len      = l34_len;
        plan_next.seg_size     = ((cfg.max_l3_len != 16'd0) && (room < item_reg.segment_size))
                               ? room : item_reg.segment_size;
        plan_next.pay_len      = item_reg.frame_len - {8'd0, hdr_len};
        plan_next.start_seq    = item_reg.start_seq;
        plan_next.start_ip_id  = item_reg.start_ip_id;
        plan_next.tcp_flags    = item_reg.tcp_flags;
    end

    // segment count bound without a divider
    always_comb
    begin
        limit    = ProdW'(MAX_SEGMENTS) * ProdW'(plan_reg.seg_size);
        too_many = (plan_reg.status == STATUS_SEGMENT) && (ProdW'(plan_reg.pay_len) > limit);
        q_data   = plan_reg;
        if (too_many)
        begin
            q_data.status = STATUS_TOO_MANY;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ch.ready = 1'b0;
        q_push      = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    state_next = F_CLASSIFY;
                end
            end
            F_CLASSIFY:
            begin
                state_next = F_LIMIT;
            end
            F_LIMIT:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg <= in_ch.payload;
        end
        if (state_reg == F_CLASSIFY)
        begin
            plan_reg <= plan_next;
        end
    end

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> (state_reg == F_IDLE))
        else $error("front ready outside idle");

    a_accept_to_push: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> ##1 (state_reg == F_LIMIT))
        else $error("front did not reach limit check");

    a_limit_status: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && (q_data.status == STATUS_SEGMENT)) |-> (q_data.seg_size != 16'd0))
        else $error("accepted frame with zero segment size");

endmodule

// File: src/tsp_queue.sv
module tsp_queue import tsp_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  plan_t push_data,
    input  logic  pop,
    output plan_t pop_data,
    output logic  full,
    output logic  empty
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    plan_t            entry_reg [QUEUE_DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;

    always_comb
    begin
        full        = (count_reg == CntW'(QUEUE_DEPTH));
        empty       = (count_reg == '0);
        pop_data    = entry_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");

endmodule

// File: src/tsp_back.sv
module tsp_back import tsp_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  plan_t         q_data,
    output logic          q_pop,
    tsp_result_if.source  out_ch
);

    plan_t       plan_reg;
    logic        busy_reg, busy_next;
    logic [16:0] off_reg;
    logic [15:0] id_reg;
    logic        first_reg;
    result_t     out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    logic [16:0] rem;
    logic        seg_last;
    logic        done;
    logic [15:0] plen;
    logic        load;
    logic [11:0] flags;

    always_comb
    begin
        rem      = plan_reg.pay_len - off_reg;
        seg_last = (rem <= {1'b0, plan_reg.seg_size});
        plen     = seg_last ? rem[15:0] : plan_reg.seg_size;
        done     = (plan_reg.status != STATUS_SEGMENT) || seg_last;
        load     = busy_reg && (!out_valid_reg || out_ch.ready);
        q_pop    = !busy_reg && !q_empty;

        flags = plan_reg.tcp_flags;
        if (!seg_last)
        begin
            flags = flags & ~FLAGS_LAST_ONLY;
        end
        if (!first_reg)
        begin
            flags = flags & ~FLAGS_FIRST_ONLY;
        end

        out_next = '0;
        if (plan_reg.status != STATUS_SEGMENT)
        begin
            out_next.status = plan_reg.status;
            out_next.last   = 1'b1;
        end
        else
        begin
            out_next.status          = STATUS_SEGMENT;
            out_next.seg_seq         = plan_reg.start_seq + {15'd0, off_reg};
            out_next.payload_offset  = {9'd0, plan_reg.header_len} + off_reg;
            out_next.payload_len     = plen;
            out_next.l3_length_field = (plan_reg.is_ipv6 ? {10'd0, plan_reg.tcp_len}
                                                         : {9'd0, plan_reg.l34_len}) + plen;
            out_next.seg_ip_id       = plan_reg.is_ipv6 ? 16'd0 : id_reg;
            out_next.seg_tcp_flags   = flags;
            out_next.offload_kind    = plan_reg.offload_kind;
            out_next.is_ipv6         = plan_reg.is_ipv6;
            out_next.header_len      = plan_reg.header_len;
            out_next.last            = seg_last;
        end

        busy_next = busy_reg;
        if (q_pop)
        begin
            busy_next = 1'b1;
        end
        else if (load && done)
        begin
            busy_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        out_ch.valid   = out_valid_reg;
        out_ch.payload = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            plan_reg  <= q_data;
            off_reg   <= '0;
            id_reg    <= q_data.start_ip_id;
            first_reg <= 1'b1;
        end
        else if (load)
        begin
            off_reg   <= off_reg + {1'b0, plen};
            id_reg    <= id_reg + 16'd1;
            first_reg <= 1'b0;
        end
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    a_pop_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (busy_reg && (off_reg == 17'd0) && first_reg))
        else $error("run did not start at offset zero");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (plan_reg.status == STATUS_SEGMENT)) |-> (off_reg < plan_reg.pay_len))
        else $error("segment offset ran past payload");

    a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status != STATUS_SEGMENT))
            |-> (out_reg.last && (out_reg.payload_len == 16'd0)))
        else $error("rejected frame result malformed");

endmodule

// File: src/tcp_segmentation_planner.sv
// channel   dir  handshake        payload
// in_ch     in   valid / ready    item_t: parsed headers of one large frame
// out_ch    out  valid / ready    result_t: one segment descriptor or reject
// cfg       in   cfg_we           cfg_index selects register, cfg_wdata value
//
// front takes one item at a time: capture, classify, segment count bound
// back gives one descriptor per cycle while out_ch is ready, after loading each frame's plan
// a frame gives up to MAX_SEGMENTS segment descriptors in the back
// a two-entry plan queue lets the front classify the next frame during a run
// output register holds a result under stall; rst_n clears control state only
module tcp_segmentation_planner import tsp_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    tsp_item_if.sink      in_ch,
    tsp_result_if.source  out_ch,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_wdata
);

    cfg_t  cfg_reg;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    plan_t q_push_data;
    plan_t q_pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HW_CHECKSUM:     cfg_reg.hw_checksum     <= cfg_wdata[0];
                CFG_LINK_HEADER_LEN: cfg_reg.link_header_len <= cfg_wdata[7:0];
                CFG_MAX_L3_LEN:      cfg_reg.max_l3_len      <= cfg_wdata;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    tsp_front #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .in_ch  (in_ch),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_push_data)
    );

    tsp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    tsp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_pop_data),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule
